/* rtl/core/pnbf_pkg.sv */
// ----------------------------------------------------------------------------
// pnbf_pkg
// shared constants for the point near box filter: register map, fixed point
// format of the pose matrix and pipeline depth
// ----------------------------------------------------------------------------
package pnbf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd4;

    // register widths
    localparam int ROW_W    = 64;
    localparam int HALF_W   = 48;
    localparam int THRESH_W = 32;

    // matrix entries are q2.14, translation in mm, 16 bits each
    localparam int MAT_W      = 16;
    localparam int MAT_FRAC   = 14;
    localparam int ROUND_BIAS = 8192;
    localparam int EXT_W      = 16;

    // register stages from input to output word
    localparam int NUM_STAGES = 5;
    // stages inside the per-axis datapath
    localparam int AXIS_STAGES = 4;

endpackage

/* rtl/core/pnbf_in_if.sv */
// ----------------------------------------------------------------------------
// pnbf_in_if
// point input channel: coordinates, normal and last marker with valid/ready
// ----------------------------------------------------------------------------
interface pnbf_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic signed [15:0]            nx;
    logic signed [15:0]            ny;
    logic signed [15:0]            nz;
    logic                          in_last;

    modport source (output valid, px, py, pz, nx, ny, nz, in_last, input ready);
    modport sink   (input valid, px, py, pz, nx, ny, nz, in_last, output ready);
endinterface

/* rtl/core/pnbf_out_if.sv */
// ----------------------------------------------------------------------------
// pnbf_out_if
// result channel: point and normal passed through, keep and last flags
// ----------------------------------------------------------------------------
interface pnbf_out_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_px;
    logic signed [COORD_WIDTH-1:0] out_py;
    logic signed [COORD_WIDTH-1:0] out_pz;
    logic signed [15:0]            out_nx;
    logic signed [15:0]            out_ny;
    logic signed [15:0]            out_nz;
    logic                          keep;
    logic                          out_last;

    modport source (output valid, out_px, out_py, out_pz, out_nx, out_ny, out_nz,
                    keep, out_last, input ready);
    modport sink   (input valid, out_px, out_py, out_pz, out_nx, out_ny, out_nz,
                    keep, out_last, output ready);
endinterface

/* rtl/core/pnbf_axis.sv */
// ----------------------------------------------------------------------------
// pnbf_axis
// one axis of the box test: matrix row times point, rounding, saturation,
// fold, clamp against the half extent and squaring, four register stages
// ----------------------------------------------------------------------------
module pnbf_axis
    import pnbf_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic [AXIS_STAGES-1:0]        i_en,
    input  logic [ROW_W-1:0]              i_row,
    input  logic [EXT_W-1:0]              i_half,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    input  logic signed [COORD_WIDTH-1:0] i_pz,
    output logic [2*(COORD_WIDTH+4)-1:0]  o_dsq
);

    localparam int XF_W = COORD_WIDTH + 4;
    localparam int PW   = MAT_W + COORD_WIDTH;
    localparam int AW   = COORD_WIDTH + 19;
    localparam int QW   = AW - MAT_FRAC;

    logic signed [MAT_W-1:0] w_r0, w_r1, w_r2, w_t;
    logic signed [PW-1:0]    r_p0, r_p1, r_p2;
    logic signed [AW-1:0]    n_acc, r_acc;
    logic signed [QW-1:0]    w_q;
    logic signed [XF_W-1:0]  w_sat;
    logic [XF_W-1:0]         w_mag, w_half, n_d, r_d;
    logic [2*XF_W-1:0]       r_sq;

    assign w_r0 = i_row[MAT_W-1:0];
    assign w_r1 = i_row[2*MAT_W-1:MAT_W];
    assign w_r2 = i_row[3*MAT_W-1:2*MAT_W];
    assign w_t  = i_row[4*MAT_W-1:3*MAT_W];

    // stage 0: three products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p0 <= PW'(w_r0 * i_px);
            r_p1 <= PW'(w_r1 * i_py);
            r_p2 <= PW'(w_r2 * i_pz);
        end
    end

    // stage 1: exact sum with translation and rounding bias
    assign n_acc = AW'(r_p0) + AW'(r_p1) + AW'(r_p2)
                 + (AW'(w_t) <<< MAT_FRAC) + AW'(ROUND_BIAS);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_acc <= n_acc;
        end
    end

    // stage 2: floor shift, saturate, fold and clamp
    always_comb begin
        w_q = r_acc[AW-1:MAT_FRAC];
        if (w_q[QW-1] != w_q[QW-2]) begin
            w_sat = w_q[QW-1] ? {1'b1, {(XF_W-1){1'b0}}} : {1'b0, {(XF_W-1){1'b1}}};
        end else begin
            w_sat = w_q[XF_W-1:0];
        end
        // the most negative value folds to its exact magnitude
        w_mag  = w_sat[XF_W-1] ? (~w_sat + 1'b1) : w_sat;
        w_half = XF_W'(i_half);
        n_d    = (w_mag > w_half) ? (w_mag - w_half) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_d <= n_d;
        end
    end

    // stage 3: square of the outside distance
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_sq <= r_d * r_d;
        end
    end

    assign o_dsq = r_sq;

endmodule

/* rtl/core/point_near_box_filter_unit.sv */
// ----------------------------------------------------------------------------
// point_near_box_filter_unit
// keeps depth points that lie within a squared distance of an oriented box
// ----------------------------------------------------------------------------
// throughput: one word per cycle, limited by nothing but the output handshake
// each stage holds its word only while the stage after it is blocked, so
// bubbles close up and a point is taken while a result waits at the output
// reset (i_rst_n low at a clock edge) empties the pipeline and clears all
// configuration registers to zero
// ----------------------------------------------------------------------------
module point_near_box_filter_unit
    import pnbf_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pnbf_in_if.sink               i_pt,
    pnbf_out_if.source            o_res
);

    localparam int XF_W  = COORD_WIDTH + 4;
    localparam int SQ_W  = 2 * XF_W;
    localparam int SUM_W = SQ_W + 2;

    // word carried beside the datapath
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic signed [COORD_WIDTH-1:0] pz;
        logic signed [15:0]            nx;
        logic signed [15:0]            ny;
        logic signed [15:0]            nz;
        logic                          last;
    } t_pay;

    // configuration registers
    logic [ROW_W-1:0]    r_row_x, r_row_y, r_row_z;
    logic [HALF_W-1:0]   r_half;
    logic [THRESH_W-1:0] r_thresh;

    // pipeline control
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;
    t_pay                  r_pay [NUM_STAGES];
    t_pay                  w_in_pay;

    // per-axis squared distances and final decision
    logic [SQ_W-1:0]  w_dsq_x, w_dsq_y, w_dsq_z;
    logic [SUM_W-1:0] w_sum;
    logic             n_keep, r_keep;

    // ------------------------------------------------------------------
    // configuration writes, only while the pipeline is idle; the block does not enforce this
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x  <= '0;
            r_row_y  <= '0;
            r_row_z  <= '0;
            r_half   <= '0;
            r_thresh <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_X:  r_row_x  <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_Y:  r_row_y  <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_Z:  r_row_z  <= i_cfg_data[ROW_W-1:0];
                CFG_HALF:   r_half   <= i_cfg_data[HALF_W-1:0];
                CFG_THRESH: r_thresh <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stall chain: a stage loads when it is empty or its successor moves
    // ------------------------------------------------------------------
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_res.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_pt.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_pt.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // pass-through word travels with the valid bits
    // ------------------------------------------------------------------
    assign w_in_pay = '{px: i_pt.px, py: i_pt.py, pz: i_pt.pz,
                        nx: i_pt.nx, ny: i_pt.ny, nz: i_pt.nz,
                        last: i_pt.in_last};

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pay[0] <= w_in_pay;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_en[k]) begin
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // three axis datapaths, stages 0 to 3, fed from the input word
    // ------------------------------------------------------------------
    pnbf_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
        .i_clk  (i_clk),
        .i_en   (w_en[AXIS_STAGES-1:0]),
        .i_row  (r_row_x),
        .i_half (r_half[EXT_W-1:0]),
        .i_px   (i_pt.px),
        .i_py   (i_pt.py),
        .i_pz   (i_pt.pz),
        .o_dsq  (w_dsq_x)
    );

    pnbf_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
        .i_clk  (i_clk),
        .i_en   (w_en[AXIS_STAGES-1:0]),
        .i_row  (r_row_y),
        .i_half (r_half[2*EXT_W-1:EXT_W]),
        .i_px   (i_pt.px),
        .i_py   (i_pt.py),
        .i_pz   (i_pt.pz),
        .o_dsq  (w_dsq_y)
    );

    pnbf_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_z (
        .i_clk  (i_clk),
        .i_en   (w_en[AXIS_STAGES-1:0]),
        .i_row  (r_row_z),
        .i_half (r_half[3*EXT_W-1:2*EXT_W]),
        .i_px   (i_pt.px),
        .i_py   (i_pt.py),
        .i_pz   (i_pt.pz),
        .o_dsq  (w_dsq_z)
    );

    // ------------------------------------------------------------------
    // stage 4: exact sum of squares against the threshold, output register
    // ------------------------------------------------------------------
    assign w_sum  = SUM_W'(w_dsq_x) + SUM_W'(w_dsq_y) + SUM_W'(w_dsq_z);
    assign n_keep = (w_sum <= SUM_W'(r_thresh));

    always_ff @(posedge i_clk) begin
        if (w_en[NUM_STAGES-1]) begin
            r_keep <= n_keep;
        end
    end

    assign o_res.valid    = r_vld[NUM_STAGES-1];
    assign o_res.out_px   = r_pay[NUM_STAGES-1].px;
    assign o_res.out_py   = r_pay[NUM_STAGES-1].py;
    assign o_res.out_pz   = r_pay[NUM_STAGES-1].pz;
    assign o_res.out_nx   = r_pay[NUM_STAGES-1].nx;
    assign o_res.out_ny   = r_pay[NUM_STAGES-1].ny;
    assign o_res.out_nz   = r_pay[NUM_STAGES-1].nz;
    assign o_res.out_last = r_pay[NUM_STAGES-1].last;
    assign o_res.keep     = r_keep;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a full pipeline with a blocked output takes no new point
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !o_res.ready) |-> !i_pt.ready)
        else $error("point taken while pipeline full and output blocked");

    // an empty output stage always lets the whole chain advance
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NUM_STAGES-1] |-> i_pt.ready)
        else $error("input blocked although output stage is empty");

    // a blocked stage keeps its word
    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !w_en[2]) |=> r_vld[2])
        else $error("blocked stage dropped its word");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for point_near_box_filter_unit: a directed walk over
// extreme points and register settings, then random point clouds under
// changing box setups and back-pressure, each result word checked against a
// keep flag given by hand or a behavioral box-distance predictor
// ----------------------------------------------------------------------------
module tb;
    import pnbf_pkg::*;

    localparam int     COORD_W     = 16;
    localparam int     XF_W        = COORD_W + 4;
    localparam longint XF_MAX      = (longint'(1) <<< (XF_W - 1)) - 1;
    localparam longint XF_MIN      = -XF_MAX - 1;
    localparam logic [THRESH_W-1:0] THRESH_MAX = 32'hFFFE_0001;
    localparam int     NUM_PHASES  = 8;
    localparam int     PHASE_ITEMS = 128;
    localparam int     CYCLE_LIMIT = 200_000;

    // one point word as it enters, and the result word it should produce
    typedef struct {
        logic signed [COORD_W-1:0] px, py, pz;
        logic signed [15:0]        nx, ny, nz;
        logic                      last;
    } t_point;

    typedef struct {
        t_point pt;
        logic   keep;
    } t_result;

    // directed walk: either a register write or a point word
    typedef enum logic {ROW_POINT, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_point                pt;
        logic                  fixed_keep;  // keep flag given by hand
        logic                  keep_val;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pnbf_in_if  #(.COORD_WIDTH(COORD_W)) pt_if ();
    pnbf_out_if #(.COORD_WIDTH(COORD_W)) res_if ();

    point_near_box_filter_unit #(
        .COORD_WIDTH(COORD_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_res      (res_if)
    );

    // bench copy of the register file, updated on every write
    logic [ROW_W-1:0]    pose_row [3];
    logic [HALF_W-1:0]   half_len;
    logic [THRESH_W-1:0] dist_limit_sq;

    t_result     awaited_results [$];
    t_row        directed_rows [$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor: move the point into the box frame, fold into the positive
    // octant, clamp against the half lengths and sum the squared overshoot
    // ------------------------------------------------------------------------
    function automatic logic near_box(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic signed [COORD_W-1:0] z);
        logic signed [MAT_W-1:0] r0, r1, r2, shift_mm;
        longint acc, v, mag, over, dist_sq;
        dist_sq = 0;
        for (int k = 0; k < 3; k++) begin
            {shift_mm, r2, r1, r0} = pose_row[k];
            // exact q2.14 dot product plus translation, then round half up
            acc = longint'(r0) * longint'(x) + longint'(r1) * longint'(y)
                + longint'(r2) * longint'(z) + (longint'(shift_mm) <<< MAT_FRAC)
                + ROUND_BIAS;
            v = acc >>> MAT_FRAC;
            // saturate to the transform width
            if (v > XF_MAX) v = XF_MAX;
            if (v < XF_MIN) v = XF_MIN;
            mag  = (v < 0) ? -v : v;
            over = mag - longint'(half_len[EXT_W*k +: EXT_W]);
            if (over < 0) over = 0;
            dist_sq += over * over;
        end
        return dist_sq <= longint'(dist_limit_sq);
    endfunction

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // register write, only called with the pipe empty; the enable is dropped
    // by whatever word follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ROW_X:  pose_row[0]   = data;
            CFG_ROW_Y:  pose_row[1]   = data;
            CFG_ROW_Z:  pose_row[2]   = data;
            CFG_HALF:   half_len      = data[HALF_W-1:0];
            CFG_THRESH: dist_limit_sq = data[THRESH_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // send one point word, with random idle cycles ahead of it; the expected
    // result is queued at the edge the word is taken
    task automatic push_point(input t_point p, input logic fixed_keep,
                              input logic keep_val);
        t_result r;
        i_cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.px      <= p.px;
        pt_if.py      <= p.py;
        pt_if.pz      <= p.pz;
        pt_if.nx      <= p.nx;
        pt_if.ny      <= p.ny;
        pt_if.nz      <= p.nz;
        pt_if.in_last <= p.last;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        r.pt   = p;
        r.keep = fixed_keep ? keep_val : near_box(p.px, p.py, p.pz);
        awaited_results.push_back(r);
    endtask

    // hold the input quiet until every queued result word has come back;
    // every point yields a word, so an empty queue means an empty pipe
    task automatic wait_drained();
        pt_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // directed walk
    // ------------------------------------------------------------------------
    task automatic add_point(input int x, input int y, input int z,
                             input int nx, input int ny, input int nz,
                             input logic last, input logic fixed_keep,
                             input logic keep_val);
        t_row row;
        row.kind       = ROW_POINT;
        row.idx        = '0;
        row.data       = '0;
        row.pt.px      = COORD_W'(x);
        row.pt.py      = COORD_W'(y);
        row.pt.pz      = COORD_W'(z);
        row.pt.nx      = 16'(nx);
        row.pt.ny      = 16'(ny);
        row.pt.nz      = 16'(nz);
        row.pt.last    = last;
        row.fixed_keep = fixed_keep;
        row.keep_val   = keep_val;
        directed_rows.push_back(row);
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        t_row row;
        row.pt         = '{default: '0};
        row.fixed_keep = 1'b0;
        row.keep_val   = 1'b0;
        row.kind       = ROW_REG;
        row.idx        = idx;
        row.data       = data;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed();
        // registers at reset: zero matrix sends every point to the origin
        add_point(0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b1);
        add_point(32767, 32767, 32767, 32767, 32767, 32767, 1'b0, 1'b1, 1'b1);
        add_point(-32768, -32768, -32768, -32768, -32768, -32768, 1'b1, 1'b1, 1'b1);
        add_point(32767, -32768, 0, -1, 21845, -21846, 1'b0, 1'b1, 1'b1);
        // identity pose inside the largest box: always inside, always kept
        add_reg(CFG_ROW_X, 64'h0000_0000_0000_4000);
        add_reg(CFG_ROW_Y, 64'h0000_0000_4000_0000);
        add_reg(CFG_ROW_Z, 64'h0000_4000_0000_0000);
        add_reg(CFG_HALF, 64'h0000_FFFF_FFFF_FFFF);
        add_reg(CFG_THRESH, 64'h0);
        add_point(32767, -32768, 12345, 1, -1, 0, 1'b0, 1'b1, 1'b1);
        add_point(-32768, 32767, -1, -16384, 16384, 0, 1'b0, 1'b1, 1'b1);
        add_point(0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b1);
        // cube with 100 mm half lengths, zero threshold: faces kept, one mm outside dropped,
        // negative side folds onto the positive one
        add_reg(CFG_HALF, 64'h0000_0064_0064_0064);
        add_point(100, -100, 100, 5, 6, 7, 1'b0, 1'b1, 1'b1);
        add_point(101, 0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b0);
        add_point(0, 0, -101, 0, 0, 0, 1'b0, 1'b1, 1'b0);
        // threshold of one square mm
        add_reg(CFG_THRESH, 64'h1);
        add_point(-101, 0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b1);
        add_point(101, 101, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0);
        // extreme matrix entries and translations, point box, widest threshold
        add_reg(CFG_ROW_X, 64'h8000_8000_8000_8000);
        add_reg(CFG_ROW_Y, 64'h7FFF_7FFF_7FFF_7FFF);
        add_reg(CFG_ROW_Z, 64'h8000_7FFF_8000_7FFF);
        add_reg(CFG_HALF, 64'h0);
        add_reg(CFG_THRESH, 64'(THRESH_MAX));
        add_point(32767, 32767, 32767, 0, 0, 0, 1'b0, 1'b0, 1'b0);
        add_point(-32768, -32768, -32768, 0, 0, 0, 1'b0, 1'b0, 1'b0);
        add_point(32767, -32768, 32767, 0, 0, 0, 1'b0, 1'b0, 1'b0);
        add_reg(CFG_ROW_Z, 64'hFFFF_FFFF_FFFF_FFFF);
        add_point(-32768, 32767, -32768, 0, 0, 0, 1'b1, 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // box setups for the random phases
    // ------------------------------------------------------------------------
    task automatic load_box_setup(input int kind);
        logic [CFG_DATA_W-1:0] row_val [3];
        logic [HALF_W-1:0]     half_val;
        logic [THRESH_W-1:0]   thr_val;
        int                    r;
        case (kind)
            0: begin
                // near-identity rotation, modest offset, box near the origin
                for (int k = 0; k < 3; k++) begin
                    row_val[k] = '0;
                    for (int c = 0; c < 3; c++)
                        row_val[k][16*c +: 16] = (c == k) ? 16'(rand_span(12288, 20480))
                                                          : 16'(rand_span(-4096, 4096));
                    row_val[k][63:48] = 16'(rand_span(-2000, 2000));
                end
                for (int k = 0; k < 3; k++)
                    half_val[16*k +: 16] = 16'(rand_span(0, 1500));
                r       = rand_span(0, 1500);
                thr_val = THRESH_W'(r * r);
            end
            1: begin
                // every bit at random, but a threshold above THRESH_MAX loses its top bit
                for (int k = 0; k < 3; k++)
                    row_val[k] = {$urandom, $urandom};
                half_val = {16'($urandom), $urandom};
                thr_val  = $urandom;
                if (thr_val > THRESH_MAX) thr_val[31] = 1'b0;
            end
            default: begin
                // corners of the register ranges
                for (int k = 0; k < 3; k++)
                    case ($urandom_range(0, 3))
                        0: row_val[k] = 64'h0;
                        1: row_val[k] = 64'hFFFF_FFFF_FFFF_FFFF;
                        2: row_val[k] = 64'h7FFF_7FFF_7FFF_7FFF;
                        default: row_val[k] = 64'h8000_8000_8000_8000;
                    endcase
                half_val = $urandom_range(0, 1) ? '1 : '0;
                thr_val  = $urandom_range(0, 1) ? THRESH_MAX : '0;
            end
        endcase
        write_reg(CFG_ROW_X, row_val[0]);
        write_reg(CFG_ROW_Y, row_val[1]);
        write_reg(CFG_ROW_Z, row_val[2]);
        write_reg(CFG_HALF, 64'(half_val));
        write_reg(CFG_THRESH, 64'(thr_val));
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, compare each taken word with the oldest
    // expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk)
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic compare_field(input string name, input longint want,
                                 input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result word with none expected, expected none actual px %0d",
                         $time, res_if.out_px);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("out_px", longint'(want.pt.px), longint'(res_if.out_px));
                compare_field("out_py", longint'(want.pt.py), longint'(res_if.out_py));
                compare_field("out_pz", longint'(want.pt.pz), longint'(res_if.out_pz));
                compare_field("out_nx", longint'(want.pt.nx), longint'(res_if.out_nx));
                compare_field("out_ny", longint'(want.pt.ny), longint'(res_if.out_ny));
                compare_field("out_nz", longint'(want.pt.nz), longint'(res_if.out_nz));
                compare_field("keep", longint'(want.keep), longint'(res_if.keep));
                compare_field("out_last", longint'(want.pt.last),
                              longint'(res_if.out_last));
            end
        end
    end

    // hard stop in case a handshake never completes
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[point_near_box_filter_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_point p;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        pt_if.valid   <= 1'b0;
        pt_if.px      <= '0;
        pt_if.py      <= '0;
        pt_if.pz      <= '0;
        pt_if.nx      <= '0;
        pt_if.ny      <= '0;
        pt_if.nz      <= '0;
        pt_if.in_last <= 1'b0;
        // registers come out of reset as zero
        for (int k = 0; k < 3; k++) pose_row[k] = '0;
        half_len      = '0;
        dist_limit_sq = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk, no idling on either side
        build_directed();
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                wait_drained();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                push_point(directed_rows[i].pt, directed_rows[i].fixed_keep,
                           directed_rows[i].keep_val);
            end
        end

        // random clouds: idle mode cycles through none, sender, receiver, both
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 72; end
                default: begin send_idle_pct = 29; recv_stall_pct <= 29; end
            endcase
            load_box_setup(phase % 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mostly points around the box, the rest anywhere
                if ($urandom_range(0, 9) < 7) begin
                    p.px = COORD_W'(rand_span(-3000, 3000));
                    p.py = COORD_W'(rand_span(-3000, 3000));
                    p.pz = COORD_W'(rand_span(-3000, 3000));
                end else begin
                    p.px = COORD_W'($urandom);
                    p.py = COORD_W'($urandom);
                    p.pz = COORD_W'($urandom);
                end
                p.nx   = 16'($urandom);
                p.ny   = 16'($urandom);
                p.nz   = 16'($urandom);
                p.last = (n == PHASE_ITEMS - 1) || ($urandom_range(0, 15) == 0);
                // halfway through, let the pipe run dry before going on
                if (n == PHASE_ITEMS / 2) wait_drained();
                push_point(p, 1'b0, 1'b0);
            end
        end

        // drain, then watch a while longer for stray words
        wait_drained();
        recv_stall_pct <= 0;
        repeat (NUM_STAGES * 4) @(posedge i_clk);

        if (mismatches == 0)
            $display("[point_near_box_filter_unit] OK");
        else
            $display("[point_near_box_filter_unit] ERROR");
        $finish;
    end

endmodule
